// File: rtl/roll_angle_profile_generator_unit_assert.svh
// assertion macros for the roll angle profile generator
`ifndef ROLL_ANGLE_PROFILE_GENERATOR_UNIT_ASSERT_SVH
`define ROLL_ANGLE_PROFILE_GENERATOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked on the rising edge out of reset
`define RAPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RAPG_ASSERT_IMP(label, ante, cons, msg)
`define RAPG_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/rapg_pkg.sv
// shared types and constants of the roll angle profile generator
package rapg_pkg;

  localparam int MAX_STEPS = 64;
  localparam int ADDR_W    = $clog2(MAX_STEPS);
  localparam int STEP_W    = 7;
  localparam int HEAD_W    = 9;
  localparam int DUR_W     = 14;
  localparam int TIME_W    = 32;
  localparam int DIR_W     = 2;
  localparam int CMD_W     = 2;
  localparam int DVD_W     = HEAD_W + TIME_W;
  localparam int CNT_W     = $clog2(DVD_W + 1);

  localparam logic [HEAD_W:0]  DEG_FULL = (HEAD_W + 1)'(360);
  localparam logic [STEP_W-1:0] MAX_CNT = STEP_W'(MAX_STEPS);

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [DIR_W-1:0] DIR_SHORTEST = 2'd2;

  localparam logic [2:0] CFG_STEP_COUNT_ADDR = 3'd0;

  typedef struct packed {
    logic [DIR_W-1:0]  direction;
    logic [HEAD_W-1:0] heading;
    logic [DUR_W-1:0]  duration;
  } entry_t;

endpackage

// File: rtl/roll_angle_profile_generator_unit.sv
// roll angle profile generator: step table, sequencer and shared divider
// Items are taken with start while busy is low. Table writes and unused
// commands finish in the accepting cycle; a begin item keeps busy high
// while it reads step 0 from the table. A query that is invalid at once
// (no profile, the step index at or past the count, or an advance past the
// count) is answered on out_strobe in the next cycle with busy staying low.
// A valid query reads the current and previous table entries through the
// single read port; shortest and zero-duration steps answer then, others
// run the radix-2 restoring divider one quotient bit a cycle over the 41-bit
// product. The result is held for one cycle and must be taken.
module roll_angle_profile_generator_unit
  import rapg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [5:0]          in_entry_index,
  input  logic [DIR_W-1:0]    in_entry_direction,
  input  logic [HEAD_W-1:0]   in_entry_heading,
  input  logic [DUR_W-1:0]    in_entry_duration,
  input  logic [TIME_W-1:0]   in_now_ms,
  output logic                out_strobe,
  output logic [HEAD_W-1:0]   out_target_angle,
  output logic                out_angle_valid,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_BG_RD   = 8'b0000_0010,
    S_BG_SET  = 8'b0000_0100,
    S_RD_CUR  = 8'b0000_1000,
    S_RD_PREV = 8'b0001_0000,
    S_MUL     = 8'b0010_0000,
    S_DIV     = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_t;

  entry_t             mem [MAX_STEPS];
  entry_t             rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               active_r, active_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  end_r, end_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               adv_r, adv_nxt;
  entry_t             cur_r, cur_nxt;
  logic [HEAD_W-1:0]  prev_r, prev_nxt;
  logic               neg_r, neg_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [DUR_W-1:0]   rem_r, rem_nxt;
  logic [HEAD_W-1:0]  mod_r, mod_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               strobe_r, strobe_nxt;
  logic [HEAD_W-1:0]  angle_r, angle_nxt;
  logic               valid_r, valid_nxt;
  logic [STEP_W-1:0]  step_count_r;

  logic               accept;
  logic               cfg_wr;
  logic [STEP_W-1:0]  live_cnt;
  logic [STEP_W-1:0]  step_inc;
  logic [HEAD_W-1:0]  head_wr;
  logic [HEAD_W-1:0]  prev_head;
  logic [HEAD_W:0]    diff;
  logic [HEAD_W-1:0]  diff_mag;
  logic [DUR_W:0]     trial;
  logic               trial_ge;
  logic [HEAD_W:0]    mod_dbl;
  logic [HEAD_W:0]    fin_sum;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == CFG_STEP_COUNT_ADDR[2]);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == CFG_STEP_COUNT_ADDR[2]) ?
                    {{(32 - STEP_W){1'b0}}, step_count_r} : 32'd0;
  assign live_cnt = (step_count_r > MAX_CNT) ? MAX_CNT : step_count_r;
  assign step_inc = step_r + STEP_W'(1);
  assign head_wr  = ({1'b0, in_entry_heading} >= DEG_FULL) ?
                    HEAD_W'({1'b0, in_entry_heading} - DEG_FULL) : in_entry_heading;

  assign out_strobe       = strobe_r;
  assign out_target_angle = angle_r;
  assign out_angle_valid  = valid_r;

  always_comb begin
    case (state_r)
      S_BG_RD:   rd_addr = '0;
      S_RD_PREV: rd_addr = ADDR_W'(step_r - STEP_W'(1));
      default:   rd_addr = step_r[ADDR_W-1:0];
    endcase
  end

  // step table
  always_ff @(posedge clk) begin
    if (accept && (in_cmd == CMD_WRITE) && ({1'b0, in_entry_index} < MAX_CNT)) begin
      mem[in_entry_index[ADDR_W-1:0]] <= '{direction: in_entry_direction,
                                           heading:   head_wr,
                                           duration:  in_entry_duration};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign prev_head = (step_r == '0) ? '0 : rd_data_r.heading;
  assign diff      = {1'b0, cur_r.heading} - {1'b0, prev_head};
  assign diff_mag  = diff[HEAD_W] ? HEAD_W'(-diff) : diff[HEAD_W-1:0];
  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign trial_ge  = (trial >= {1'b0, cur_r.duration});
  assign mod_dbl   = {mod_r, trial_ge};
  assign fin_sum   = neg_r ?
                     ((prev_r >= mod_r) ? {1'b0, prev_r} - {1'b0, mod_r}
                                        : {1'b0, prev_r} + DEG_FULL - {1'b0, mod_r}) :
                     {1'b0, prev_r} + {1'b0, mod_r};

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    active_nxt  = active_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    elapsed_nxt = elapsed_r;
    adv_nxt     = adv_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    neg_nxt     = neg_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    mod_nxt     = mod_r;
    cnt_nxt     = cnt_r;
    strobe_nxt  = 1'b0;
    angle_nxt   = angle_r;
    valid_nxt   = valid_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_BEGIN)) begin
          step_nxt   = '0;
          active_nxt = 1'b1;
          start_nxt  = in_now_ms;
          state_nxt  = S_BG_RD;
        end else if (accept && (in_cmd == CMD_QUERY)) begin
          if (!active_r || (step_r >= live_cnt)) begin
            strobe_nxt = 1'b1;
            angle_nxt  = '0;
            valid_nxt  = 1'b0;
          end else if (in_now_ms > end_r) begin
            if (step_inc >= live_cnt) begin
              step_nxt   = live_cnt;
              strobe_nxt = 1'b1;
              angle_nxt  = '0;
              valid_nxt  = 1'b0;
            end else begin
              step_nxt    = step_inc;
              start_nxt   = end_r;
              elapsed_nxt = in_now_ms - end_r;
              adv_nxt     = 1'b1;
              state_nxt   = S_RD_CUR;
            end
          end else begin
            elapsed_nxt = in_now_ms - start_r;
            adv_nxt     = 1'b0;
            state_nxt   = S_RD_CUR;
          end
        end
      end
      S_BG_RD: begin
        state_nxt = S_BG_SET;
      end
      S_BG_SET: begin
        end_nxt   = start_r + TIME_W'(rd_data_r.duration);
        state_nxt = S_IDLE;
      end
      S_RD_CUR: begin
        state_nxt = S_RD_PREV;
      end
      S_RD_PREV: begin
        cur_nxt = rd_data_r;
        if (adv_r) begin
          end_nxt = start_r + TIME_W'(rd_data_r.duration);
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prev_nxt = prev_head;
        neg_nxt  = diff[HEAD_W];
        dvd_nxt  = DVD_W'(diff_mag) * DVD_W'(elapsed_r);
        rem_nxt  = '0;
        mod_nxt  = '0;
        cnt_nxt  = CNT_W'(DVD_W);
        if ((cur_r.direction == DIR_SHORTEST) || (cur_r.duration == '0)) begin
          strobe_nxt = 1'b1;
          angle_nxt  = cur_r.heading;
          valid_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = trial_ge ? DUR_W'(trial - {1'b0, cur_r.duration}) : trial[DUR_W-1:0];
        mod_nxt = (mod_dbl >= DEG_FULL) ? HEAD_W'(mod_dbl - DEG_FULL) : mod_dbl[HEAD_W-1:0];
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        strobe_nxt = 1'b1;
        angle_nxt  = (fin_sum >= DEG_FULL) ? HEAD_W'(fin_sum - DEG_FULL)
                                           : fin_sum[HEAD_W-1:0];
        valid_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      active_r     <= 1'b0;
      start_r      <= '0;
      end_r        <= '0;
      strobe_r     <= 1'b0;
      step_count_r <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      active_r <= active_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr) begin
        step_count_r <= pwdata[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    adv_r     <= adv_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    neg_r     <= neg_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    mod_r     <= mod_nxt;
    cnt_r     <= cnt_nxt;
    angle_r   <= angle_nxt;
    valid_r   <= valid_nxt;
  end

`include "roll_angle_profile_generator_unit_assert.svh"

  `RAPG_ASSERT_IMP(a_invalid_zero, out_strobe && !out_angle_valid, out_target_angle == '0, "invalid item with nonzero angle")
  `RAPG_ASSERT_IMP(a_angle_range, out_strobe && out_angle_valid, {1'b0, out_target_angle} < DEG_FULL, "angle out of range")
  `RAPG_ASSERT_NXT(a_query_moves, start && !busy && (in_cmd == CMD_QUERY), out_strobe || busy, "query item dropped")
  `RAPG_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start), "busy without an accepted item")

endmodule

// File: bench/tb_roll_angle_profile_generator_unit.sv
// testbench for the roll angle profile generator: predicted answers checked item by item
module tb_roll_angle_profile_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rapg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [DIR_W-1:0] DIR_CW     = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CCW    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_SPARE  = 2'd3;
  localparam longint FULL_TURN    = 360;
  localparam int DRAIN_CYCLES     = 60;
  localparam int TARGET_ITEMS     = 820;

  typedef struct packed {
    logic [HEAD_W-1:0] angle;
    logic              valid;
  } angle_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [5:0]          in_entry_index = '0;
  logic [DIR_W-1:0]    in_entry_direction = '0;
  logic [HEAD_W-1:0]   in_entry_heading = '0;
  logic [DUR_W-1:0]    in_entry_duration = '0;
  logic [TIME_W-1:0]   in_now_ms = '0;
  logic                out_strobe;
  logic [HEAD_W-1:0]   out_target_angle;
  logic                out_angle_valid;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // profile state as the generator should hold it
  logic [DIR_W-1:0]    dir_tab [MAX_STEPS];
  logic [HEAD_W-1:0]   head_tab [MAX_STEPS];
  logic [DUR_W-1:0]    dur_tab [MAX_STEPS];
  bit                  entry_written [MAX_STEPS];
  int unsigned         cur_step = 0;
  bit                  profile_on = 1'b0;
  logic [TIME_W-1:0]   step_begin_ms = '0;
  logic [TIME_W-1:0]   step_end_ms = '0;
  logic [STEP_W-1:0]   step_count = '0;

  angle_t              pending_angles [$];
  int                  errors = 0;
  int                  items_sent = 0;
  int                  burst_left = 1;
  bit                  no_gaps = 1'b0;

  always #6 clk = ~clk;

  roll_angle_profile_generator_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_entry_direction (in_entry_direction),
    .in_entry_heading   (in_entry_heading),
    .in_entry_duration  (in_entry_duration),
    .in_now_ms          (in_now_ms),
    .out_strobe         (out_strobe),
    .out_target_angle   (out_target_angle),
    .out_angle_valid    (out_angle_valid),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  task automatic advance_profile(input logic [CMD_W-1:0] cmd, input logic [5:0] idx,
                                 input logic [DIR_W-1:0] dir, input logic [HEAD_W-1:0] head,
                                 input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
    int unsigned live;
    bit          gone;
    longint      tgt, prv, diff, prog, r;
    longint unsigned abs_d, mag;
    logic [TIME_W-1:0] elapsed;
    live = (step_count > MAX_STEPS) ? MAX_STEPS : step_count;
    gone = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        dir_tab[idx] = dir;
        head_tab[idx] = HEAD_W'(head % 360);
        dur_tab[idx] = dur;
        entry_written[idx] = 1'b1;
      end
      CMD_BEGIN: begin
        cur_step = 0;
        profile_on = 1'b1;
        step_begin_ms = now;
        step_end_ms = now + TIME_W'(dur_tab[0]);
      end
      CMD_QUERY: begin
        if (!profile_on || cur_step >= live) begin
          pending_angles.push_back('{angle: '0, valid: 1'b0});
        end else begin
          if (now > step_end_ms) begin
            cur_step++;
            if (cur_step >= live) begin
              cur_step = live;
              gone = 1'b1;
            end else begin
              step_begin_ms = step_end_ms;
              step_end_ms = step_begin_ms + TIME_W'(dur_tab[cur_step]);
            end
          end
          if (gone) begin
            pending_angles.push_back('{angle: '0, valid: 1'b0});
          end else if (dir_tab[cur_step] == DIR_SHORTEST) begin
            pending_angles.push_back('{angle: head_tab[cur_step], valid: 1'b1});
          end else begin
            tgt = head_tab[cur_step];
            prv = (cur_step == 0) ? 0 : head_tab[cur_step - 1];
            diff = tgt - prv;
            elapsed = now - step_begin_ms;
            if (dur_tab[cur_step] == '0) begin
              prog = diff;
            end else begin
              abs_d = (diff < 0) ? -diff : diff;
              mag = abs_d * elapsed / dur_tab[cur_step];
              prog = longint'(mag % FULL_TURN);
              if (diff < 0) prog = -prog;
            end
            r = (prv + prog) % FULL_TURN;
            if (r < 0) r += FULL_TURN;
            pending_angles.push_back('{angle: HEAD_W'(r), valid: 1'b1});
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    angle_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: result with none expected: angle %0d valid %0d", $time,
                 out_target_angle, out_angle_valid);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (out_target_angle !== want.angle) begin
          $display("%0t: target_angle expected %0d actual %0d", $time, want.angle,
                   out_target_angle);
          errors++;
        end
        if (out_angle_valid !== want.valid) begin
          $display("%0t: angle_valid expected %0d actual %0d", $time, want.valid,
                   out_angle_valid);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [5:0] idx,
                           input logic [DIR_W-1:0] dir, input logic [HEAD_W-1:0] head,
                           input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
    int gap;
    start <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= idx;
    in_entry_direction <= dir;
    in_entry_heading <= head;
    in_entry_duration <= dur;
    in_now_ms <= now;
    do @(posedge clk); while (busy !== 1'b0);
    advance_profile(cmd, idx, dir, head, dur, now);
    if (cmd != CMD_UNUSED) items_sent++;
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // item with only a command and a time, entry fields random
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now);
    send_item(cmd, 6'($urandom), DIR_W'($urandom), HEAD_W'($urandom), DUR_W'($urandom), now);
  endtask

  // sender held off until every answer is back and the block has settled
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step_count(input logic [STEP_W-1:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_STEP_COUNT_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    step_count = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [HEAD_W-1:0] pick_heading();
    return HEAD_W'(($urandom_range(0, 7) == 0) ? $urandom_range(360, 511)
                                               : $urandom_range(0, 359));
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DUR_W'($urandom_range(10000, 16383));
      2: return 14'd9999;
      default: return DUR_W'($urandom_range(1, 1500));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return 7'd1;
    if (r < 75) return STEP_W'($urandom_range(2, 8));
    if (r < 85) return STEP_W'($urandom_range(9, 63));
    if (r < 92) return 7'd64;
    return STEP_W'($urandom_range(65, 127));
  endfunction

  task automatic write_random_entry(input logic [5:0] idx);
    send_item(CMD_WRITE, idx, DIR_W'($urandom_range(0, 3)), pick_heading(), pick_duration(),
              $urandom);
  endtask

  task automatic test_no_profile();
    send_cmd(CMD_QUERY, $urandom);
    send_cmd(CMD_UNUSED, $urandom);
  endtask

  // one profile through interpolation, zero duration, jump, spare direction and overrun
  task automatic test_directed_steps();
    logic [TIME_W-1:0] t0;
    t0 = 32'hFFFF_FF00;
    send_item(CMD_WRITE, 6'd0, DIR_CW, 9'd90, 14'd100, $urandom);
    send_item(CMD_WRITE, 6'd1, DIR_CCW, 9'd500, 14'd0, $urandom);
    send_item(CMD_WRITE, 6'd2, DIR_SHORTEST, 9'd359, 14'd16383, $urandom);
    send_item(CMD_WRITE, 6'd3, DIR_SPARE, 9'd0, 14'd9999, $urandom);
    send_item(CMD_WRITE, 6'd63, DIR_CCW, 9'd511, 14'd16383, $urandom);
    write_step_count(7'd4);
    send_cmd(CMD_BEGIN, t0);
    send_cmd(CMD_QUERY, t0 + 32'd50);
    send_cmd(CMD_QUERY, t0 + 32'd100);
    send_cmd(CMD_QUERY, t0 + 32'd101);
    send_cmd(CMD_QUERY, t0 + 32'd200);
    send_cmd(CMD_QUERY, 32'h0000_5000);
    send_cmd(CMD_QUERY, 32'h0000_7800);
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF);
  endtask

  // restart with time behind the step start, then an empty table
  task automatic test_restart_and_empty();
    send_cmd(CMD_BEGIN, 32'd1000);
    send_cmd(CMD_QUERY, 32'd500);
    write_step_count(7'd0);
    send_cmd(CMD_BEGIN, 32'hFFFF_FFFF);
    send_cmd(CMD_QUERY, 32'd0);
  endtask

  task automatic test_random_profiles();
    int                phase, nq, live, r;
    logic [STEP_W-1:0] cnt;
    logic [TIME_W-1:0] now;
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase)
        0: cnt = 7'd127;
        1: cnt = 7'd64;
        default: cnt = pick_count();
      endcase
      live = (cnt > MAX_STEPS) ? MAX_STEPS : cnt;
      no_gaps = 1'b0;
      for (int i = 0; i < live; i++)
        if (!entry_written[i]) write_random_entry(6'(i));
      write_step_count(cnt);
      no_gaps = ($urandom_range(0, 3) == 0);
      now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
      send_cmd(CMD_BEGIN, now);
      nq = $urandom_range(2, 2 * live + 4);
      repeat (nq) begin
        if ($urandom_range(0, 19) < 3) begin
          case ($urandom_range(0, 3))
            0: write_random_entry(6'($urandom));
            1: send_cmd(CMD_UNUSED, $urandom);
            2: send_cmd(CMD_BEGIN, $urandom);
            default: send_cmd(CMD_QUERY, $urandom);
          endcase
        end else begin
          r = $urandom_range(0, 9);
          if (r < 5) now = step_begin_ms + $urandom_range(0, step_end_ms - step_begin_ms);
          else if (r < 8) now = step_end_ms + $urandom_range(1, 300);
          else if (r < 9) now = step_end_ms;
          else now = $urandom;
          send_cmd(CMD_QUERY, now);
        end
      end
      phase++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_profile();
    test_directed_steps();
    test_restart_and_empty();
    test_random_profiles();
    wait_drained();
    if (errors == 0)
      $display("tb_roll_angle_profile_generator_unit OK");
    else
      $display("tb_roll_angle_profile_generator_unit NOT OK");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_roll_angle_profile_generator_unit NOT OK");
    $finish;
  end

endmodule

// File: roll_angle_profile_generator_unit.f
+incdir+rtl
rtl/rapg_pkg.sv
rtl/roll_angle_profile_generator_unit.sv
bench/tb_roll_angle_profile_generator_unit.sv
